[rtl/core/pibt_pkg.sv]
`timescale 1ns / 1ps

package pibt_pkg;

   // Field widths fixed by the line format.
   localparam int OPCODE_BITS    = 2;
   localparam int BYTE_BITS      = 8;
   localparam int CFG_BITS       = 16;
   localparam int MODE_BITS      = 3;
   localparam int COUNT_BITS     = 5;
   localparam int CSR_INDEX_BITS = 3;

   // Defaults for the top-level parameters.
   localparam int TIMER_BITS_DEFAULT  = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Opcodes on the request channel.
   localparam logic [OPCODE_BITS-1:0] OP_TICK     = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_PULSE    = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_TRANSMIT = 2'd2;

   // Control register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BIT_HALF_PERIOD = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IGNORE_WINDOW   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ZERO_THRESHOLD  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BYTE_TIMEOUT    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_TIMEOUT   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IDLE_TIMEOUT    = 3'd5;

   // Control register reset values.
   localparam logic [CFG_BITS-1:0] RST_BIT_HALF_PERIOD = 16'd500;
   localparam logic [CFG_BITS-1:0] RST_IGNORE_WINDOW   = 16'd250;
   localparam logic [CFG_BITS-1:0] RST_ZERO_THRESHOLD  = 16'd750;
   localparam logic [CFG_BITS-1:0] RST_BYTE_TIMEOUT    = 16'd1500;
   localparam logic [CFG_BITS-1:0] RST_FRAME_TIMEOUT   = 16'd3000;
   localparam logic [CFG_BITS-1:0] RST_IDLE_TIMEOUT    = 16'd5000;

   // A good byte is one start clock pulse plus eight bit slots of two pulses.
   localparam logic [COUNT_BITS-1:0] RX_FULL_COUNT = 5'd17;

   typedef enum logic [1:0] {
      EV_TICK,
      EV_PULSE,
      EV_TRANSMIT,
      EV_NOP
   } event_kind_type;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_IDLE       = 3'd0,
      MODE_IGNORE     = 3'd1,
      MODE_SAMPLE     = 3'd2,
      MODE_BYTE_DONE  = 3'd3,
      MODE_FRAME_DONE = 3'd4,
      MODE_SENDING    = 3'd5
   } mode_type;

   typedef struct packed {
      event_kind_type       kind;
      logic [BYTE_BITS-1:0] tx_byte;
   } event_type;

   typedef struct packed {
      logic                 drive_pulse;
      logic                 tx_accepted;
      logic                 rx_valid;
      logic [BYTE_BITS-1:0] rx_value;
      logic                 rx_bad_count;
      mode_type             link_mode;
   } result_type;

endpackage

[rtl/core/pibt_req_if.sv]
`timescale 1ns / 1ps

interface pibt_req_if;
   logic                               valid;
   logic                               ready;
   logic [pibt_pkg::OPCODE_BITS-1:0]   opcode;
   logic [pibt_pkg::BYTE_BITS-1:0]     tx_byte;

   modport source (output valid, output opcode, output tx_byte, input ready);
   modport sink (input valid, input opcode, input tx_byte, output ready);
endinterface

[rtl/core/pibt_rsp_if.sv]
`timescale 1ns / 1ps

interface pibt_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             drive_pulse;
   logic                             tx_accepted;
   logic                             rx_valid;
   logic [pibt_pkg::BYTE_BITS-1:0]   rx_value;
   logic                             rx_bad_count;
   logic [pibt_pkg::MODE_BITS-1:0]   link_mode;

   modport source (output valid, output drive_pulse, output tx_accepted, output rx_valid,
                   output rx_value, output rx_bad_count, output link_mode, input ready);
   modport sink (input valid, input drive_pulse, input tx_accepted, input rx_valid,
                 input rx_value, input rx_bad_count, input link_mode, output ready);
endinterface

[rtl/core/pibt_front.sv]
`timescale 1ns / 1ps

module pibt_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [pibt_pkg::OPCODE_BITS-1:0] req_opcode,
   input  logic [pibt_pkg::BYTE_BITS-1:0]   req_tx_byte,
   output logic                             push,
   output pibt_pkg::event_type              push_event,
   input  logic                             queue_full
);
   import pibt_pkg::*;

   logic      front_valid_ff;
   logic      front_valid_in;
   event_type front_event_ff;
   event_type front_event_in;
   logic      accept;

   // The stage frees up whenever its item moves into the queue.
   assign push      = front_valid_ff && !queue_full;
   assign req_ready = !front_valid_ff || !queue_full;
   assign accept    = req_valid && req_ready;

   // Opcode decode into an event kind.
   always_comb begin
      front_event_in.tx_byte = req_tx_byte;
      unique case (req_opcode)
         OP_TICK:     front_event_in.kind = EV_TICK;
         OP_PULSE:    front_event_in.kind = EV_PULSE;
         OP_TRANSMIT: front_event_in.kind = EV_TRANSMIT;
         default:     front_event_in.kind = EV_NOP;
      endcase
   end

   always_comb begin
      front_valid_in = front_valid_ff;
      if (accept) begin
         front_valid_in = 1'b1;
      end else if (push) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_event_ff <= front_event_in;
      end
   end

   assign push_event = front_event_ff;

endmodule

[rtl/core/pibt_queue.sv]
`timescale 1ns / 1ps

module pibt_queue #(
   parameter int DEPTH = pibt_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pibt_pkg::event_type push_event,
   output logic                full,
   input  logic                pop,
   output logic                pop_valid,
   output pibt_pkg::event_type pop_event
);
   import pibt_pkg::*;

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS_Q = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

   event_type                 entries_ff [DEPTH];
   logic [PTR_BITS-1:0]       wr_ptr_ff;
   logic [PTR_BITS-1:0]       wr_ptr_in;
   logic [PTR_BITS-1:0]       rd_ptr_ff;
   logic [PTR_BITS-1:0]       rd_ptr_in;
   logic [COUNT_BITS_Q-1:0]   count_ff;
   logic [COUNT_BITS_Q-1:0]   count_in;
   logic                      do_push;
   logic                      do_pop;

   assign full      = (count_ff == COUNT_BITS_Q'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_event = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_BITS_Q'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_BITS_Q'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_event;
      end
   end

endmodule

[rtl/core/pibt_back.sv]
`timescale 1ns / 1ps

module pibt_back #(
   parameter int TIMER_BITS = pibt_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                ev_valid,
   input  pibt_pkg::event_type                 ev,
   output logic                                ev_pop,
   input  logic                                csr_we,
   input  logic [pibt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [pibt_pkg::CFG_BITS-1:0]       csr_wdata,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output pibt_pkg::result_type                rsp_data
);
   import pibt_pkg::*;

   localparam int CMP_BITS = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;

   // Control registers.
   logic [CFG_BITS-1:0] bit_half_period_ff;
   logic [CFG_BITS-1:0] ignore_window_ff;
   logic [CFG_BITS-1:0] zero_threshold_ff;
   logic [CFG_BITS-1:0] byte_timeout_ff;
   logic [CFG_BITS-1:0] frame_timeout_ff;
   logic [CFG_BITS-1:0] idle_timeout_ff;

   // Link state.
   mode_type              mode_ff;
   mode_type              mode_in;
   logic [COUNT_BITS-1:0] pulse_count_ff;
   logic [COUNT_BITS-1:0] pulse_count_in;
   logic [BYTE_BITS-1:0]  rx_shift_ff;
   logic [BYTE_BITS-1:0]  rx_shift_in;
   logic [BYTE_BITS-1:0]  tx_shift_ff;
   logic [BYTE_BITS-1:0]  tx_shift_in;
   logic [TIMER_BITS-1:0] elapsed_ff;
   logic [TIMER_BITS-1:0] elapsed_in;
   logic [TIMER_BITS-1:0] deadline_ff;
   logic [TIMER_BITS-1:0] deadline_in;

   // Output register.
   logic       rsp_valid_ff;
   result_type rsp_data_ff;
   result_type result_in;

   logic [TIMER_BITS-1:0] elapsed_inc;
   logic [TIMER_BITS-1:0] half_period_t;
   logic [TIMER_BITS-1:0] four_half_t;
   logic [TIMER_BITS-1:0] send_deadline;
   logic [COUNT_BITS-1:0] count_inc;
   logic [COUNT_BITS-1:0] count_inc2;
   logic                  fire;
   logic                  frame_end;
   logic                  gap_long;
   logic                  pulse_taken;
   logic                  out_free;

   // The output register takes a new result when empty or being drained.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign ev_pop    = ev_valid && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Shared timer arithmetic.
   assign elapsed_inc   = elapsed_ff + TIMER_BITS'(1);
   assign fire          = (mode_ff != MODE_IDLE) && (elapsed_inc == deadline_ff);
   assign half_period_t = TIMER_BITS'(bit_half_period_ff);
   // The last clock pulse moves the deadline by one slot and then three more.
   assign four_half_t   = TIMER_BITS'({bit_half_period_ff, 2'b00});
   assign count_inc     = pulse_count_ff + COUNT_BITS'(1);
   assign count_inc2    = pulse_count_ff + COUNT_BITS'(2);
   assign frame_end     = count_inc[0] && count_inc[4];
   assign send_deadline = deadline_ff + (frame_end ? four_half_t : half_period_t);
   assign gap_long      = CMP_BITS'(elapsed_ff) > CMP_BITS'(zero_threshold_ff);
   assign pulse_taken   = (mode_ff == MODE_IDLE) || (mode_ff == MODE_SAMPLE) ||
                          (mode_ff == MODE_BYTE_DONE) || (mode_ff == MODE_FRAME_DONE);

   // Next state of the link for the event at the head of the queue.
   always_comb begin
      mode_in        = mode_ff;
      pulse_count_in = pulse_count_ff;
      rx_shift_in    = rx_shift_ff;
      tx_shift_in    = tx_shift_ff;
      elapsed_in     = elapsed_ff;
      deadline_in    = deadline_ff;
      unique case (ev.kind)
         EV_TICK: begin
            elapsed_in = elapsed_inc;
            if (fire) begin
               unique case (mode_ff)
                  MODE_SENDING: begin
                     deadline_in = send_deadline;
                     if (frame_end) begin
                        mode_in        = MODE_FRAME_DONE;
                        pulse_count_in = '0;
                     end else begin
                        pulse_count_in = count_inc;
                     end
                     if (!count_inc[0]) begin
                        tx_shift_in = {tx_shift_ff[BYTE_BITS-2:0], 1'b0};
                     end
                  end
                  MODE_IGNORE: begin
                     mode_in     = MODE_SAMPLE;
                     deadline_in = TIMER_BITS'(byte_timeout_ff);
                  end
                  MODE_SAMPLE: begin
                     mode_in        = MODE_BYTE_DONE;
                     deadline_in    = TIMER_BITS'(frame_timeout_ff);
                     pulse_count_in = '0;
                  end
                  MODE_BYTE_DONE: begin
                     mode_in     = MODE_FRAME_DONE;
                     deadline_in = TIMER_BITS'(idle_timeout_ff);
                  end
                  MODE_FRAME_DONE: begin
                     mode_in = MODE_IDLE;
                  end
                  default: begin
                     mode_in = mode_ff;
                  end
               endcase
            end
         end
         EV_PULSE: begin
            if (pulse_taken) begin
               elapsed_in     = '0;
               pulse_count_in = count_inc;
               if (pulse_count_ff != '0) begin
                  // A long gap is a clock pulse with its data pulse missing.
                  if (gap_long) begin
                     pulse_count_in = count_inc2;
                     rx_shift_in    = {rx_shift_ff[BYTE_BITS-2:0], 1'b0};
                  end else if (!count_inc[0]) begin
                     rx_shift_in = {rx_shift_ff[BYTE_BITS-2:0], 1'b1};
                  end
               end
               mode_in     = MODE_IGNORE;
               deadline_in = TIMER_BITS'(ignore_window_ff);
            end
         end
         EV_TRANSMIT: begin
            if (mode_ff == MODE_IDLE) begin
               deadline_in    = elapsed_ff + half_period_t;
               pulse_count_in = COUNT_BITS'(1);
               mode_in        = MODE_SENDING;
               tx_shift_in    = ev.tx_byte;
            end
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase
   end

   // Result fields for the same event.
   always_comb begin
      result_in                = '0;
      result_in.link_mode      = mode_in;
      unique case (ev.kind)
         EV_TICK: begin
            if (fire && (mode_ff == MODE_SENDING)) begin
               // Odd slots carry the clock pulse, even slots the data bit.
               result_in.drive_pulse = count_inc[0] ? 1'b1 : tx_shift_ff[BYTE_BITS-1];
            end else if (fire && (mode_ff == MODE_SAMPLE)) begin
               if (pulse_count_ff == RX_FULL_COUNT) begin
                  result_in.rx_valid = 1'b1;
                  result_in.rx_value = rx_shift_ff;
               end else begin
                  result_in.rx_bad_count = 1'b1;
               end
            end
         end
         EV_TRANSMIT: begin
            if (mode_ff == MODE_IDLE) begin
               result_in.drive_pulse = 1'b1;
               result_in.tx_accepted = 1'b1;
            end
         end
         default: begin
            result_in.drive_pulse = 1'b0;
         end
      endcase
   end

   // State registers advance once per popped event.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         pulse_count_ff <= '0;
         rx_shift_ff    <= '0;
         tx_shift_ff    <= '0;
         elapsed_ff     <= '0;
         deadline_ff    <= '0;
      end else if (ev_pop) begin
         mode_ff        <= mode_in;
         pulse_count_ff <= pulse_count_in;
         rx_shift_ff    <= rx_shift_in;
         tx_shift_ff    <= tx_shift_in;
         elapsed_ff     <= elapsed_in;
         deadline_ff    <= deadline_in;
      end
   end

   // Control register writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_half_period_ff <= RST_BIT_HALF_PERIOD;
         ignore_window_ff   <= RST_IGNORE_WINDOW;
         zero_threshold_ff  <= RST_ZERO_THRESHOLD;
         byte_timeout_ff    <= RST_BYTE_TIMEOUT;
         frame_timeout_ff   <= RST_FRAME_TIMEOUT;
         idle_timeout_ff    <= RST_IDLE_TIMEOUT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BIT_HALF_PERIOD: bit_half_period_ff <= csr_wdata;
            CSR_IGNORE_WINDOW:   ignore_window_ff   <= csr_wdata;
            CSR_ZERO_THRESHOLD:  zero_threshold_ff  <= csr_wdata;
            CSR_BYTE_TIMEOUT:    byte_timeout_ff    <= csr_wdata;
            CSR_FRAME_TIMEOUT:   frame_timeout_ff   <= csr_wdata;
            CSR_IDLE_TIMEOUT:    idle_timeout_ff    <= csr_wdata;
            default:             bit_half_period_ff <= bit_half_period_ff;
         endcase
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= ev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ev_pop) begin
         rsp_data_ff <= result_in;
      end
   end

endmodule

[rtl/core/pulse_interval_bus_transceiver.sv]
`timescale 1ns / 1ps

// Pulse-interval single-wire transceiver, stepped by events.
// req_bus carries one event per transfer: a timer tick, a line pulse seen,
// or a transmit request with its byte. rsp_bus returns exactly one result
// per event, in order: whether to drive a pulse now, transmit acceptance,
// a received byte or a count error at the byte timeout, and the link mode.
// csr_we/csr_index/csr_wdata write the six timing registers; write them
// only while no event is in flight.
// A result passes through the input stage, the event queue and the output
// register before it is presented. Throughput: one event per cycle while
// rsp_bus does not stall, as the back end computes each event's next link
// state and result combinationally and registers them when it pops the event.
// When rsp_bus stalls, the output register holds its result, the queue
// fills, and req_bus.ready drops once the input stage cannot drain; no
// event is lost. Reset is synchronous: the link returns to idle, counters
// and shift registers clear, timing registers take their defaults, and
// the queue and output register empty.
module pulse_interval_bus_transceiver #(
   parameter int TIMER_BITS  = pibt_pkg::TIMER_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = pibt_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   pibt_req_if.sink                            req_bus,
   pibt_rsp_if.source                          rsp_bus,
   input  logic                                csr_we,
   input  logic [pibt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [pibt_pkg::CFG_BITS-1:0]       csr_wdata
);
   import pibt_pkg::*;

   logic       push;
   event_type  push_event;
   logic       queue_full;
   logic       pop;
   logic       pop_valid;
   event_type  pop_event;
   logic       rsp_valid;
   result_type rsp_data;

   // Front end: accept and decode events.
   pibt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_ready   (req_bus.ready),
      .req_opcode  (req_bus.opcode),
      .req_tx_byte (req_bus.tx_byte),
      .push        (push),
      .push_event  (push_event),
      .queue_full  (queue_full)
   );

   // Event queue between the two halves.
   pibt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_event (push_event),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_event  (pop_event)
   );

   // Back end: link state machine, timer and output register.
   pibt_back #(
      .TIMER_BITS (TIMER_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .ev_valid  (pop_valid),
      .ev        (pop_event),
      .ev_pop    (pop),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_bus.valid        = rsp_valid;
   assign rsp_bus.drive_pulse  = rsp_data.drive_pulse;
   assign rsp_bus.tx_accepted  = rsp_data.tx_accepted;
   assign rsp_bus.rx_valid     = rsp_data.rx_valid;
   assign rsp_bus.rx_value     = rsp_data.rx_value;
   assign rsp_bus.rx_bad_count = rsp_data.rx_bad_count;
   assign rsp_bus.link_mode    = rsp_data.link_mode;

`ifndef SYNTH
   // An accepted transmit always starts with a clock pulse and enters sending.
   a_tx_starts: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.tx_accepted) |->
         (rsp_bus.drive_pulse && (rsp_bus.link_mode == MODE_SENDING)))
      else $error("accepted transmit without start pulse or sending mode");

   // A byte verdict is exclusive and only occurs on entering byte done.
   a_rx_verdict: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.rx_valid || rsp_bus.rx_bad_count)) |->
         (!(rsp_bus.rx_valid && rsp_bus.rx_bad_count) &&
          (rsp_bus.link_mode == MODE_BYTE_DONE)))
      else $error("receive verdict inconsistent with link mode");

   // Nothing is presented in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_bus.valid)
      else $error("result presented right after reset");
`endif

endmodule

[dv/pulse_interval_bus_transceiver_tb.sv]
`timescale 1ns / 1ps

module pulse_interval_bus_transceiver_tb;
   import pibt_pkg::*;

   typedef logic [TIMER_BITS_DEFAULT-1:0] timer_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] bit_half_period;
      logic [CFG_BITS-1:0] ignore_window;
      logic [CFG_BITS-1:0] zero_threshold;
      logic [CFG_BITS-1:0] byte_timeout;
      logic [CFG_BITS-1:0] frame_timeout;
      logic [CFG_BITS-1:0] idle_timeout;
   } timing_type;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PATTERN,
      STALL_LONG
   } stall_style_type;

   // Cycles without any transfer before the run is declared hung.
   localparam int QUIET_LIMIT = 1000;
   localparam int EVENTS_PER_PHASE = 40;

   // Tracks the link state as events are accepted and checks results in order.
   class transceiver_tracker;
      timing_type            timing;
      mode_type              mode;
      logic [COUNT_BITS-1:0] pulse_count;
      logic [BYTE_BITS-1:0]  rx_shift;
      logic [BYTE_BITS-1:0]  tx_shift;
      timer_type             elapsed;
      timer_type             deadline;
      result_type            pending_results[$];
      int                    mismatches;
      int                    results_checked;
      int                    bytes_received;
      int                    count_errors;
      int                    transmits;

      function new();
         timing.bit_half_period = RST_BIT_HALF_PERIOD;
         timing.ignore_window   = RST_IGNORE_WINDOW;
         timing.zero_threshold  = RST_ZERO_THRESHOLD;
         timing.byte_timeout    = RST_BYTE_TIMEOUT;
         timing.frame_timeout   = RST_FRAME_TIMEOUT;
         timing.idle_timeout    = RST_IDLE_TIMEOUT;
         mode = MODE_IDLE;
         pulse_count = '0;
         rx_shift = '0;
         tx_shift = '0;
         elapsed = '0;
         deadline = '0;
         mismatches = 0;
         results_checked = 0;
         bytes_received = 0;
         count_errors = 0;
         transmits = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] index,
                                   logic [CFG_BITS-1:0] value);
         case (index)
            CSR_BIT_HALF_PERIOD: timing.bit_half_period = value;
            CSR_IGNORE_WINDOW:   timing.ignore_window = value;
            CSR_ZERO_THRESHOLD:  timing.zero_threshold = value;
            CSR_BYTE_TIMEOUT:    timing.byte_timeout = value;
            CSR_FRAME_TIMEOUT:   timing.frame_timeout = value;
            CSR_IDLE_TIMEOUT:    timing.idle_timeout = value;
            default: ;
         endcase
      endfunction

      // Advance the link by one accepted event and queue the result it causes.
      function void note_event(event_kind_type kind, logic [BYTE_BITS-1:0] data);
         result_type            outcome;
         timer_type             gap;
         logic [COUNT_BITS-1:0] prior;
         outcome = '0;
         case (kind)
            EV_TICK: begin
               elapsed = elapsed + timer_type'(1);
               if (mode != MODE_IDLE && elapsed == deadline) begin
                  case (mode)
                     MODE_SENDING: begin
                        deadline = deadline + timer_type'(timing.bit_half_period);
                        pulse_count = pulse_count + COUNT_BITS'(1);
                        if (pulse_count[0]) begin
                           // Clock slot; the seventeenth pulse closes the frame.
                           outcome.drive_pulse = 1'b1;
                           if (pulse_count[4]) begin
                              mode = MODE_FRAME_DONE;
                              deadline = deadline + timer_type'(3 * timing.bit_half_period);
                              pulse_count = '0;
                           end
                        end else begin
                           // Data slot: a pulse only for a 1 bit.
                           outcome.drive_pulse = tx_shift[7];
                           tx_shift = {tx_shift[6:0], 1'b0};
                        end
                     end
                     MODE_IGNORE: begin
                        mode = MODE_SAMPLE;
                        deadline = timer_type'(timing.byte_timeout);
                     end
                     MODE_SAMPLE: begin
                        mode = MODE_BYTE_DONE;
                        deadline = timer_type'(timing.frame_timeout);
                        if (pulse_count == RX_FULL_COUNT) begin
                           outcome.rx_valid = 1'b1;
                           outcome.rx_value = rx_shift;
                           bytes_received++;
                        end else begin
                           outcome.rx_bad_count = 1'b1;
                           count_errors++;
                        end
                        pulse_count = '0;
                     end
                     MODE_BYTE_DONE: begin
                        mode = MODE_FRAME_DONE;
                        deadline = timer_type'(timing.idle_timeout);
                     end
                     MODE_FRAME_DONE: mode = MODE_IDLE;
                     default: ;
                  endcase
               end
            end
            EV_PULSE: begin
               // Pulses are dropped while ignoring or sending.
               if (mode inside {MODE_IDLE, MODE_SAMPLE, MODE_BYTE_DONE, MODE_FRAME_DONE}) begin
                  gap = elapsed;
                  prior = pulse_count;
                  elapsed = '0;
                  pulse_count = pulse_count + COUNT_BITS'(1);
                  if (prior != '0) begin
                     if (gap > timer_type'(timing.zero_threshold)) begin
                        // Missing data pulse: a 0 bit worth two pulses.
                        pulse_count = pulse_count + COUNT_BITS'(1);
                        rx_shift = {rx_shift[6:0], 1'b0};
                     end else if (!pulse_count[0]) begin
                        rx_shift = {rx_shift[6:0], 1'b1};
                     end
                  end
                  mode = MODE_IGNORE;
                  deadline = timer_type'(timing.ignore_window);
               end
            end
            EV_TRANSMIT: begin
               if (mode == MODE_IDLE) begin
                  deadline = elapsed + timer_type'(timing.bit_half_period);
                  outcome.drive_pulse = 1'b1;
                  outcome.tx_accepted = 1'b1;
                  pulse_count = COUNT_BITS'(1);
                  mode = MODE_SENDING;
                  tx_shift = data;
                  transmits++;
               end
            end
            default: ;
         endcase
         outcome.link_mode = mode;
         pending_results.push_back(outcome);
      endfunction

      // Compare one result transfer against the oldest expectation.
      function void check_result(result_type seen);
         result_type want;
         if (pending_results.size() == 0) begin
            $error("Result transfer with no event outstanding (link_mode %0d)",
                   seen.link_mode);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (seen.drive_pulse !== want.drive_pulse) begin
               $error("drive_pulse: expected %0d, actual %0d",
                      want.drive_pulse, seen.drive_pulse);
               mismatches++;
            end
            if (seen.tx_accepted !== want.tx_accepted) begin
               $error("tx_accepted: expected %0d, actual %0d",
                      want.tx_accepted, seen.tx_accepted);
               mismatches++;
            end
            if (seen.rx_valid !== want.rx_valid) begin
               $error("rx_valid: expected %0d, actual %0d", want.rx_valid, seen.rx_valid);
               mismatches++;
            end
            if (seen.rx_value !== want.rx_value) begin
               $error("rx_value: expected 0x%02h, actual 0x%02h",
                      want.rx_value, seen.rx_value);
               mismatches++;
            end
            if (seen.rx_bad_count !== want.rx_bad_count) begin
               $error("rx_bad_count: expected %0d, actual %0d",
                      want.rx_bad_count, seen.rx_bad_count);
               mismatches++;
            end
            if (seen.link_mode !== want.link_mode) begin
               $error("link_mode: expected %0d, actual %0d", want.link_mode, seen.link_mode);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CFG_BITS-1:0]       csr_wdata;

   pibt_req_if req_bus();
   pibt_rsp_if rsp_bus();

   transceiver_tracker tracker = new();
   result_type         seen_result;
   int                 quiet_cycles = 0;
   int                 burst_left = 0;
   int                 events_sent = 0;

   pulse_interval_bus_transceiver DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Free-running 10 ns clock.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result monitor and hang watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_result.drive_pulse  = rsp_bus.drive_pulse;
            seen_result.tx_accepted  = rsp_bus.tx_accepted;
            seen_result.rx_valid     = rsp_bus.rx_valid;
            seen_result.rx_value     = rsp_bus.rx_value;
            seen_result.rx_bad_count = rsp_bus.rx_bad_count;
            seen_result.link_mode    = mode_type'(rsp_bus.link_mode);
            tracker.check_result(seen_result);
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, tracker.pending_results.size());
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // Result-side back-pressure in one of four stall styles, each held for a random span.
   initial begin
      stall_style_type style;
      int              style_left;
      int              stall_left;
      int              step;
      rsp_bus.ready = 1'b0;
      style = STALL_NONE;
      style_left = 0;
      stall_left = 0;
      step = 0;
      forever begin
         @(negedge clock);
         if (style_left == 0) begin
            style = stall_style_type'($urandom_range(0, 3));
            style_left = $urandom_range(50, 300);
         end
         style_left--;
         case (style)
            STALL_NONE:    rsp_bus.ready <= 1'b1;
            STALL_RANDOM:  rsp_bus.ready <= 1'($urandom_range(0, 1));
            STALL_PATTERN: begin
               step = (step + 1) % 3;
               rsp_bus.ready <= (step == 0);
            end
            default: begin
               if (stall_left > 0) begin
                  stall_left--;
                  rsp_bus.ready <= 1'b0;
               end else begin
                  rsp_bus.ready <= 1'b1;
                  if ($urandom_range(0, 11) == 0) stall_left = $urandom_range(5, 30);
               end
            end
         endcase
      end
   end

   // Present one event and hold it until the transfer; the sender works in bursts.
   task automatic send_event(input event_kind_type kind, input logic [BYTE_BITS-1:0] data);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 30);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.opcode  <= kind;
      req_bus.tx_byte <= data;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_event(kind, data);
      burst_left--;
      events_sent++;
   endtask

   task automatic run_ticks(input int count);
      repeat (count) send_event(EV_TICK, 8'($urandom));
   endtask

   task automatic tick_until_idle(input int cap);
      int spent;
      spent = 0;
      while (tracker.mode != MODE_IDLE && spent < cap) begin
         send_event(EV_TICK, 8'($urandom));
         spent++;
      end
   endtask

   // Stop sending and wait for every outstanding result.
   task automatic wait_for_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CFG_BITS-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      tracker.write_register(index, value);
   endtask

   task automatic configure(input timing_type t);
      wait_for_results();
      write_csr(CSR_BIT_HALF_PERIOD, t.bit_half_period);
      write_csr(CSR_IGNORE_WINDOW, t.ignore_window);
      write_csr(CSR_ZERO_THRESHOLD, t.zero_threshold);
      write_csr(CSR_BYTE_TIMEOUT, t.byte_timeout);
      write_csr(CSR_FRAME_TIMEOUT, t.frame_timeout);
      write_csr(CSR_IDLE_TIMEOUT, t.idle_timeout);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Ordered timings so that every receive stage can be reached.
   function automatic timing_type random_timing();
      timing_type t;
      t.bit_half_period = CFG_BITS'($urandom_range(1, 4));
      t.ignore_window   = CFG_BITS'($urandom_range(1, 3));
      t.zero_threshold  = t.ignore_window + CFG_BITS'($urandom_range(1, 4));
      t.byte_timeout    = t.zero_threshold + CFG_BITS'($urandom_range(2, 6));
      t.frame_timeout   = t.byte_timeout + CFG_BITS'($urandom_range(1, 6));
      t.idle_timeout    = t.frame_timeout + CFG_BITS'($urandom_range(1, 8));
      return t;
   endfunction

   // Gap that lands in the sample stage and reads as a data pulse.
   function automatic int short_gap();
      int lo;
      int hi;
      lo = int'(tracker.timing.ignore_window);
      hi = int'(tracker.timing.zero_threshold);
      if (hi > int'(tracker.timing.byte_timeout) - 1) hi = int'(tracker.timing.byte_timeout) - 1;
      if (hi < lo) hi = lo;
      return $urandom_range(lo, hi);
   endfunction

   // Gap that reads as a clock pulse with its data pulse missing.
   function automatic int long_gap();
      int lo;
      int hi;
      lo = int'(tracker.timing.zero_threshold) + 1;
      hi = int'(tracker.timing.byte_timeout) - 1;
      if (lo > hi) return short_gap();
      return $urandom_range(lo, hi);
   endfunction

   // Wait out a gap and then show a line pulse; a flawed pulse may be mistimed or lost.
   task automatic line_pulse(input int gap, input bit flawed);
      if (flawed && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(0, int'(tracker.timing.byte_timeout) + 3);
      end
      run_ticks(gap);
      if (!(flawed && $urandom_range(0, 7) == 0)) send_event(EV_PULSE, 8'($urandom));
   endtask

   // Let any reception or transmission in progress reach a stage that takes pulses.
   task automatic settle_receiver();
      while (tracker.mode inside {MODE_IGNORE, MODE_SAMPLE, MODE_SENDING}) begin
         send_event(EV_TICK, 8'($urandom));
      end
   endtask

   // Start pulse, then MSB first: two short gaps for a 1, one long gap for a 0.
   task automatic receive_frame(input logic [BYTE_BITS-1:0] value, input bit flawed);
      settle_receiver();
      send_event(EV_PULSE, 8'($urandom));
      for (int i = BYTE_BITS - 1; i >= 0; i--) begin
         if (value[i]) begin
            line_pulse(short_gap(), flawed);
            line_pulse(short_gap(), flawed);
         end else begin
            line_pulse(long_gap(), flawed);
         end
      end
      run_ticks(int'(tracker.timing.byte_timeout) + $urandom_range(0, 4));
   endtask

   // Transmit a byte and run it out, with dropped pulses and refused requests mixed in.
   task automatic send_frame_out(input logic [BYTE_BITS-1:0] value);
      int pick;
      tick_until_idle(200000);
      send_event(EV_TRANSMIT, value);
      while (tracker.mode != MODE_IDLE) begin
         pick = $urandom_range(0, 19);
         if (pick == 0 && tracker.mode == MODE_SENDING) send_event(EV_PULSE, 8'($urandom));
         else if (pick == 1) send_event(EV_TRANSMIT, 8'($urandom));
         else if (pick == 2) send_event(EV_NOP, 8'($urandom));
         else send_event(EV_TICK, 8'($urandom));
      end
   endtask

   // More than 32 closely spaced pulses so that the pulse counter wraps.
   task automatic pulse_storm();
      settle_receiver();
      repeat ($urandom_range(33, 40)) begin
         send_event(EV_PULSE, 8'($urandom));
         run_ticks(int'(tracker.timing.ignore_window));
      end
      run_ticks(int'(tracker.timing.byte_timeout));
   endtask

   task automatic random_noise();
      repeat ($urandom_range(1, 8)) begin
         send_event(event_kind_type'($urandom_range(0, 3)), 8'($urandom));
      end
   endtask

   // Main sequence.
   initial begin
      timing_type t;
      int         phase_start;
      int         pick;
      bit         paused;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_BIT_HALF_PERIOD;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_TICK;
      req_bus.tx_byte = '0;
      paused = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      t.bit_half_period = CFG_BITS'(2);
      t.ignore_window   = CFG_BITS'(2);
      t.zero_threshold  = CFG_BITS'(4);
      t.byte_timeout    = CFG_BITS'(8);
      t.frame_timeout   = CFG_BITS'(11);
      t.idle_timeout    = CFG_BITS'(14);
      configure(t);

      // Directed: transmit from idle, refusal while busy, pulse dropped while sending,
      // the unused opcode, a plain tick.
      send_event(EV_TRANSMIT, 8'hFF);
      send_event(EV_TRANSMIT, 8'h00);
      send_event(EV_PULSE, 8'hFF);
      send_event(EV_NOP, 8'hFF);
      send_event(EV_TICK, 8'h00);

      send_frame_out(8'h00);
      send_frame_out(8'hA5);
      receive_frame(8'hFF, 1'b0);
      receive_frame(8'h00, 1'b0);
      // A frame cut short ends in a count error at the byte timeout.
      settle_receiver();
      send_event(EV_PULSE, 8'h00);
      line_pulse(short_gap(), 1'b0);
      run_ticks(int'(tracker.timing.byte_timeout));
      // A pulse inside the ignore window is dropped.
      send_event(EV_PULSE, 8'h55);
      send_event(EV_PULSE, 8'hAA);
      pulse_storm();
      tick_until_idle(200000);

      // Random phases, mostly well-formed frames with random content.
      for (int phase = 0; phase < 5; phase++) begin
         configure(random_timing());
         phase_start = events_sent;
         while (events_sent - phase_start < EVENTS_PER_PHASE) begin
            if (phase == 2 && !paused && events_sent - phase_start > 20) begin
               wait_for_results();
               paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) receive_frame(8'($urandom), 1'b0);
            else if (pick < 72) send_frame_out(8'($urandom));
            else if (pick < 84) receive_frame(8'($urandom), 1'b1);
            else if (pick < 94) random_noise();
            else pulse_storm();
         end
         tick_until_idle(200000);
      end

      // Every register at its minimum: transmit only, one slot per tick.
      t.bit_half_period = CFG_BITS'(1);
      t.ignore_window   = CFG_BITS'(1);
      t.zero_threshold  = CFG_BITS'(1);
      t.byte_timeout    = CFG_BITS'(1);
      t.frame_timeout   = CFG_BITS'(1);
      t.idle_timeout    = CFG_BITS'(1);
      configure(t);
      repeat (4) send_frame_out(8'($urandom));

      // Maximum half period and threshold: every gap reads as a data pulse.
      t.bit_half_period = '1;
      t.ignore_window   = CFG_BITS'(1);
      t.zero_threshold  = '1;
      t.byte_timeout    = CFG_BITS'(12);
      t.frame_timeout   = CFG_BITS'(20);
      t.idle_timeout    = CFG_BITS'(30);
      configure(t);
      receive_frame(8'($urandom), 1'b0);
      tick_until_idle(200000);

      wait_for_results();
      $display("Run covered %0d events and %0d checked results.",
               events_sent, tracker.results_checked);
      $display("Bytes received: %0d, count errors: %0d, transmits accepted: %0d.",
               tracker.bytes_received, tracker.count_errors, tracker.transmits);
      if (tracker.mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/pibt_pkg.sv
rtl/core/pibt_req_if.sv
rtl/core/pibt_rsp_if.sv
rtl/core/pibt_front.sv
rtl/core/pibt_queue.sv
rtl/core/pibt_back.sv
rtl/core/pulse_interval_bus_transceiver.sv
dv/pulse_interval_bus_transceiver_tb.sv
